@@ design/tea16_block_decrypt_core_defines.svh @@
// Assertion helpers shared by the TEA-16 decrypt core.
`ifndef TEA16_BLOCK_DECRYPT_CORE_DEFINES_SVH
`define TEA16_BLOCK_DECRYPT_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TEA16_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define TEA16_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/tea16_pkg.sv @@
package tea16_pkg;

   localparam int WORD_W      = 32;
   localparam int ROUNDS      = 16;
   localparam int ROUND_IDX_W = $clog2(ROUNDS);

   localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

   // One block in flight: both data words and the key riding along with it.
   typedef struct packed {
      logic [WORD_W-1:0] lo;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] k0;
      logic [WORD_W-1:0] k1;
      logic [WORD_W-1:0] k2;
      logic [WORD_W-1:0] k3;
   } tea16_block_type;

   // TEA mixing function; all sums wrap at 32 bits.
   function automatic logic [WORD_W-1:0] tea16_mix(
      input logic [WORD_W-1:0] w,
      input logic [WORD_W-1:0] ka,
      input logic [WORD_W-1:0] kb,
      input logic [WORD_W-1:0] sum
   );
      logic [WORD_W-1:0] a;
      logic [WORD_W-1:0] b;
      logic [WORD_W-1:0] c;
      a = (w << 4) + ka;
      b = w + sum;
      c = (w >> 5) + kb;
      return a ^ b ^ c;
   endfunction

   // Running sum seen by round idx: delta * (ROUNDS - idx), mod 2^32.
   function automatic logic [WORD_W-1:0] tea16_round_sum(input logic [ROUND_IDX_W-1:0] idx);
      logic [WORD_W+ROUND_IDX_W:0] prod;
      prod = DELTA * ((WORD_W+ROUND_IDX_W+1)'(ROUNDS) - (WORD_W+ROUND_IDX_W+1)'(idx));
      return prod[WORD_W-1:0];
   endfunction

endpackage

@@ design/tea16_round_stage.sv @@
module tea16_round_stage
   import tea16_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [WORD_W-1:0]     run_sum,
   input  logic                  up_valid,
   output logic                  up_stall,
   input  tea16_block_type       up_data,
   output logic                  down_valid,
   input  logic                  down_stall,
   output tea16_block_type       down_data
);

   logic            valid_ff;
   tea16_block_type data_ff;
   tea16_block_type data_in;
   logic            advance;

   // Stage takes a new entry when empty or when its entry moves on.
   assign advance  = !valid_ff || !down_stall;
   assign up_stall = !advance;

   // One decryption round: high word first, then low word from the new high.
   always_comb begin
      data_in    = up_data;
      data_in.hi = up_data.hi - tea16_mix(up_data.lo, up_data.k2, up_data.k3, run_sum);
      data_in.lo = up_data.lo - tea16_mix(data_in.hi, up_data.k0, up_data.k1, run_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

@@ design/tea16_block_decrypt_core.sv @@
// TEA block decryptor, 16 rounds. Each transfer on the req_ channel carries a
// 64-bit ciphertext block and a 128-bit key; the rsp_ channel returns the
// plaintext in the same order. The core is a pipeline of 16 round stages, one
// register stage per round, so it takes one block per clock while req_stall is
// low, and a block passes through the stage registers in order to rsp_. Each
// stage holds its entry only while it is blocked, so bubbles close up under
// rsp_stall and req_stall rises only when all 16 stages are full and the
// output is stalled. No state is kept between blocks.
`include "tea16_block_decrypt_core_defines.svh"

module tea16_block_decrypt_core
   import tea16_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [WORD_W-1:0] req_cipher_low,
   input  logic [WORD_W-1:0] req_cipher_high,
   input  logic [WORD_W-1:0] req_key_word0,
   input  logic [WORD_W-1:0] req_key_word1,
   input  logic [WORD_W-1:0] req_key_word2,
   input  logic [WORD_W-1:0] req_key_word3,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_plain_low,
   output logic [WORD_W-1:0] rsp_plain_high
);

   logic            valid_chain [0:ROUNDS];
   logic            stall_chain [0:ROUNDS];
   tea16_block_type data_chain  [0:ROUNDS];
   logic [ROUNDS-1:0] stage_valid;

   // Input side of the pipeline
   assign valid_chain[0]   = req_valid;
   assign req_stall        = stall_chain[0];
   assign data_chain[0].lo = req_cipher_low;
   assign data_chain[0].hi = req_cipher_high;
   assign data_chain[0].k0 = req_key_word0;
   assign data_chain[0].k1 = req_key_word1;
   assign data_chain[0].k2 = req_key_word2;
   assign data_chain[0].k3 = req_key_word3;

   // Round stages
   for (genvar i = 0; i < ROUNDS; i++) begin : g_round
      tea16_round_stage u_stage (
         .clock      (clock),
         .reset      (reset),
         .run_sum    (tea16_round_sum(ROUND_IDX_W'(i))),
         .up_valid   (valid_chain[i]),
         .up_stall   (stall_chain[i]),
         .up_data    (data_chain[i]),
         .down_valid (valid_chain[i+1]),
         .down_stall (stall_chain[i+1]),
         .down_data  (data_chain[i+1])
      );
      assign stage_valid[i] = valid_chain[i+1];
   end

   // Output side
   assign stall_chain[ROUNDS] = rsp_stall;
   assign rsp_valid           = valid_chain[ROUNDS];
   assign rsp_plain_low       = data_chain[ROUNDS].lo;
   assign rsp_plain_high      = data_chain[ROUNDS].hi;

   // Checks
   `TEA16_ASSERT_IMPLIES(a_stall_only_full, clock, reset, req_stall, &stage_valid, "req_stall with a free stage")
   `TEA16_ASSERT_IMPLIES(a_empty_after_reset, clock, reset, $past(reset), stage_valid == '0, "pipeline not empty after reset")
   `TEA16_ASSERT_NEXT(a_occupancy_kept, clock, reset, !(req_valid && !req_stall) && !(rsp_valid && !rsp_stall), $countones(stage_valid) == $past($countones(stage_valid)), "block lost or duplicated")

endmodule
